FILE: src/aaqr_pkg.sv
// shared types, widths and constant tables for the quaternion rotation core
// no dependencies
`default_nettype none
package aaqr_pkg;

   localparam int PW    = 18;   // point and result width, Q7.10
   localparam int AGW   = 16;   // angle and axis width
   localparam int CW    = 20;   // cordic datapath width, Q.16
   localparam int QW    = 20;   // quaternion coefficient width
   localparam int AW    = 21;   // lane multiplier operand a width
   localparam int BW    = 20;   // lane multiplier operand b width
   localparam int TW    = 41;   // intermediate product width, Q.26
   localparam int ACCW  = 64;   // lane accumulator width
   localparam int SPLIT = 20;   // low slice width of the intermediate product

   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(39797);
   localparam logic signed [CW-1:0] HALF_PI_Q16 = CW'(102944);
   localparam logic signed [CW-1:0] PI_Q16      = CW'(205887);
   localparam logic signed [PW-1:0] OUT_MAX     = PW'(131071);
   localparam logic signed [PW-1:0] OUT_MIN     = PW'(-131072);

   typedef struct packed {
      logic clr;   // start a new sum
      logic mac;   // add this term
      logic neg;   // subtract instead of add
      logic hi;    // operand a is the upper slice
   } lane_ctrl_type;

   // arctangent of 2^-i in Q.16
   function automatic logic signed [CW-1:0] atan_q16(input logic [3:0] i);
      logic signed [CW-1:0] v;
      case (i)
         4'd0:    v = CW'(51472);
         4'd1:    v = CW'(30386);
         4'd2:    v = CW'(16055);
         4'd3:    v = CW'(8150);
         4'd4:    v = CW'(4091);
         4'd5:    v = CW'(2047);
         4'd6:    v = CW'(1024);
         4'd7:    v = CW'(512);
         4'd8:    v = CW'(256);
         4'd9:    v = CW'(128);
         4'd10:   v = CW'(64);
         4'd11:   v = CW'(32);
         4'd12:   v = CW'(16);
         4'd13:   v = CW'(8);
         4'd14:   v = CW'(4);
         default: v = CW'(2);
      endcase
      return v;
   endfunction

   // hamilton product: term j of component k is subtracted
   function automatic logic hprod_neg(input logic [1:0] k, input logic [1:0] j);
      logic n;
      case (k)
         2'd0:    n = (j != 2'd0);
         2'd1:    n = (j == 2'd3);
         2'd2:    n = (j == 2'd1);
         default: n = (j == 2'd2);
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

FILE: src/aaqr_cordic.sv
// iterative cordic giving cosine and sine of half the input angle
// depends on aaqr_pkg
`default_nettype none
module aaqr_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [aaqr_pkg::AGW-1:0] angle,
   output logic                               done,
   output logic signed [aaqr_pkg::CW-1:0]     cos_out,
   output logic signed [aaqr_pkg::CW-1:0]     sin_out
);
   import aaqr_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [3:0]           step_ff, step_in;
   logic                 negc_ff, negc_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CW-1:0] z0, dx, dy;

   // half angle in Q.16 is four times the Q3.13 angle
   assign z0 = {{(CW-AGW-2){angle[AGW-1]}}, angle, 2'b00};
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;

   // fold into the right half plane then one micro-rotation per cycle
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      negc_in = negc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         if (z0 > HALF_PI_Q16) begin
            z_in    = PI_Q16 - z0;
            negc_in = 1'b1;
         end else if (z0 < -HALF_PI_Q16) begin
            z_in    = -PI_Q16 - z0;
            negc_in = 1'b1;
         end else begin
            z_in    = z0;
            negc_in = 1'b0;
         end
      end else if (run_ff) begin
         if (!z_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_q16(step_ff);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_q16(step_ff);
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      negc_ff <= negc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = negc_ff ? -x_ff : x_ff;
   assign sin_out = y_ff;
endmodule
`default_nettype wire

FILE: src/aaqr_lane.sv
// one product lane: registered multiply then signed accumulate
// depends on aaqr_pkg
`default_nettype none
module aaqr_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire aaqr_pkg::lane_ctrl_type        ctrl,
   input  wire logic signed [aaqr_pkg::AW-1:0] op_a,
   input  wire logic signed [aaqr_pkg::BW-1:0] op_b,
   output logic signed [aaqr_pkg::ACCW-1:0]    acc
);
   import aaqr_pkg::*;

   lane_ctrl_type             ctrl_ff;
   logic signed [AW+BW-1:0]   prod_ff;
   logic signed [ACCW-1:0]    acc_ff, acc_in, ext, term;

   // align the registered product and apply its sign
   always_comb begin
      ext  = ACCW'(prod_ff);
      if (ctrl_ff.hi) begin
         ext = ext <<< SPLIT;
      end
      term = ctrl_ff.neg ? -ext : ext;
      acc_in = acc_ff;
      if (ctrl_ff.mac) begin
         acc_in = ctrl_ff.clr ? term : acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

FILE: src/axis_angle_quaternion_rotate_core.sv
// top level: cordic half angle, four product lanes, rounding and result register
// depends on aaqr_pkg, aaqr_cordic, aaqr_lane
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  mode, angle, axis_x/y/z, point_w/x/y/z
// rsp      out  rsp_valid/rsp_stall  out_w/x/y/z
//
// one beat runs through 16 cordic steps, the coefficient step, two lane multiply
// passes that each end in a drain, then rounding and output.
// the cordic and the lanes work on one beat at a time; req_stall is high meanwhile.
// a new beat is taken while a finished result still waits on rsp_stall.
// reset clears control state and the stored last result to zero.
`default_nettype none
module axis_angle_quaternion_rotate_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic signed [aaqr_pkg::AGW-1:0] req_angle,
   input  wire logic signed [aaqr_pkg::AGW-1:0] req_axis_x,
   input  wire logic signed [aaqr_pkg::AGW-1:0] req_axis_y,
   input  wire logic signed [aaqr_pkg::AGW-1:0] req_axis_z,
   input  wire logic signed [aaqr_pkg::PW-1:0]  req_point_w,
   input  wire logic signed [aaqr_pkg::PW-1:0]  req_point_x,
   input  wire logic signed [aaqr_pkg::PW-1:0]  req_point_y,
   input  wire logic signed [aaqr_pkg::PW-1:0]  req_point_z,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [aaqr_pkg::PW-1:0]       rsp_out_w,
   output logic signed [aaqr_pkg::PW-1:0]       rsp_out_x,
   output logic signed [aaqr_pkg::PW-1:0]       rsp_out_y,
   output logic signed [aaqr_pkg::PW-1:0]       rsp_out_z
);
   import aaqr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CORD = 3'd1;
   localparam logic [2:0] S_TMUL = 3'd2;
   localparam logic [2:0] S_TDRN = 3'd3;
   localparam logic [2:0] S_RMUL = 3'd4;
   localparam logic [2:0] S_RDRN = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic                        accept, cord_done, out_free;
   logic signed [CW-1:0]        cos_h, sin_h;
   logic signed [AGW-1:0]       axis_ff [3];
   logic signed [PW-1:0]        p_ff [4];
   logic signed [QW-1:0]        q_ff [4];
   logic signed [TW-1:0]        t_ff [4];
   logic signed [PW-1:0]        rnd_ff [4];
   logic signed [PW-1:0]        res_ff [4];
   logic                        rsp_valid_ff, rsp_valid_in;
   lane_ctrl_type               lctrl [4];
   logic signed [AW-1:0]        la [4];
   logic signed [BW-1:0]        lb [4];
   logic signed [ACCW-1:0]      lacc [4];
   logic signed [PW-1:0]        pin [4];
   logic signed [CW+AGW-1:0]    qprod [3];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pin[0] = req_point_w;
   assign pin[1] = req_point_x;
   assign pin[2] = req_point_y;
   assign pin[3] = req_point_z;

   aaqr_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .angle   (req_angle),
      .done    (cord_done),
      .cos_out (cos_h),
      .sin_out (sin_h)
   );

   // sequencer over the cordic, the two product passes and the output
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            if (cord_done) begin
               state_in = S_TMUL;
               cnt_in   = '0;
            end
         end
         S_TMUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               state_in = S_TDRN;
               cnt_in   = '0;
            end
         end
         S_TDRN: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               state_in = S_RMUL;
               cnt_in   = '0;
            end
         end
         S_RMUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = S_RDRN;
               cnt_in   = '0;
            end
         end
         S_RDRN: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd1) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // quaternion coefficients from the half-angle sine and the axis
   assign qprod[0] = sin_h * axis_ff[0];
   assign qprod[1] = sin_h * axis_ff[1];
   assign qprod[2] = sin_h * axis_ff[2];

   // lane operands: first pass q*p, second pass t*conj(q) in two slices
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [1:0] jt, jr, kk;
      assign kk = 2'(k);
      assign jt = cnt_ff[1:0];
      assign jr = cnt_ff[2:1];

      always_comb begin
         lctrl[k] = '0;
         la[k]    = '0;
         lb[k]    = '0;
         if (state_ff == S_TMUL) begin
            lctrl[k].mac = 1'b1;
            lctrl[k].clr = (jt == 2'd0);
            lctrl[k].neg = hprod_neg(kk, jt);
            la[k]        = AW'(q_ff[jt]);
            lb[k]        = BW'(p_ff[kk ^ jt]);
         end else if (state_ff == S_RMUL) begin
            lctrl[k].mac = 1'b1;
            lctrl[k].clr = (cnt_ff == 3'd0);
            lctrl[k].hi  = cnt_ff[0];
            lctrl[k].neg = hprod_neg(kk, jr) ^ ((kk ^ jr) != 2'd0);
            la[k]        = cnt_ff[0] ? AW'(t_ff[jr][TW-1:SPLIT])
                                     : AW'({1'b0, t_ff[jr][SPLIT-1:0]});
            lb[k]        = BW'(q_ff[kk ^ jr]);
         end
      end

      aaqr_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lctrl[k]),
         .op_a  (la[k]),
         .op_b  (lb[k]),
         .acc   (lacc[k])
      );
   end

   // merge: round to Q.10 and saturate each lane's sum
   function automatic logic signed [PW-1:0] round_sat(input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] s;
      s = (v + (ACCW'(1) <<< 31)) >>> 32;
      if (s > ACCW'(OUT_MAX)) begin
         return OUT_MAX;
      end else if (s < ACCW'(OUT_MIN)) begin
         return OUT_MIN;
      end
      return PW'(s);
   endfunction

   assign rsp_valid_in = (state_ff == S_OUT && out_free) ? 1'b1
                       : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            res_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_OUT && out_free) begin
            for (int k = 0; k < 4; k++) begin
               res_ff[k] <= rnd_ff[k];
            end
         end
      end
      if (accept) begin
         axis_ff[0] <= req_axis_x;
         axis_ff[1] <= req_axis_y;
         axis_ff[2] <= req_axis_z;
         for (int k = 0; k < 4; k++) begin
            p_ff[k] <= req_mode ? res_ff[k] : pin[k];
         end
      end
      if (state_ff == S_CORD && cord_done) begin
         q_ff[0] <= QW'(cos_h);
         for (int k = 0; k < 3; k++) begin
            q_ff[k+1] <= QW'(qprod[k] >>> 14);
         end
      end
      if (state_ff == S_TDRN && cnt_ff == 3'd1) begin
         for (int k = 0; k < 4; k++) begin
            t_ff[k] <= TW'(lacc[k]);
         end
      end
      if (state_ff == S_RDRN && cnt_ff == 3'd1) begin
         for (int k = 0; k < 4; k++) begin
            rnd_ff[k] <= round_sat(lacc[k]);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_w = res_ff[0];
   assign rsp_out_x = res_ff[1];
   assign rsp_out_y = res_ff[2];
   assign rsp_out_z = res_ff[3];
endmodule
`default_nettype wire

FILE: verif/tb_axis_angle_quaternion_rotate_core.sv
// testbench for axis_angle_quaternion_rotate_core: directed, chained and random beats,
// each result checked against a bit-exact cordic and quaternion product predictor
// depends on aaqr_pkg and the core rtl
`default_nettype none
module tb_axis_angle_quaternion_rotate_core;
   timeunit 1ns;
   timeprecision 1ps;
   import aaqr_pkg::*;

   localparam logic MODE_POINT = 1'b0;
   localparam logic MODE_CHAIN = 1'b1;
   localparam int   CYCLE_LIMIT = 600000;
   localparam int   DRAIN_CYCLES = 50;

   typedef longint quat_type [4];
   typedef struct {
      logic signed [PW-1:0] w, x, y, z;
   } rot_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = MODE_POINT;
   logic signed [AGW-1:0] req_angle = '0, req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [PW-1:0] req_point_w = '0, req_point_x = '0, req_point_y = '0;
   logic signed [PW-1:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [PW-1:0] rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z;

   rot_point_type expected_points[$];
   quat_type      prev_point = '{0, 0, 0, 0};
   int            fail_count = 0;
   int            cycles = 0;
   bit            idle_on = 1'b1;

   axis_angle_quaternion_rotate_core u_top (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // half angle cosine and sine, q.16
   function automatic void half_cos_sin(input logic signed [AGW-1:0] angle,
                                        output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(angle) * 4;
      x = 39797;
      y = 0;
      flip = 1'b0;
      if (z > 102944) begin
         z = 205887 - z;
         flip = 1'b1;
      end else if (z < -102944) begin
         z = -205887 - z;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_q16(4'(i)));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(atan_q16(4'(i)));
         end
      end
      c = flip ? -x : x;
      s = y;
   endfunction

   function automatic void hamilton(input quat_type a, input quat_type b,
                                    output quat_type r);
      r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      r[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
   endfunction

   // rotate one beat, updating the chained point
   function automatic rot_point_type rotate_point(input logic mode,
         input logic signed [AGW-1:0] angle, ax, ay, az,
         input logic signed [PW-1:0] pw, px, py, pz);
      quat_type q, qc, p, t, r;
      longint c, s, v;
      rot_point_type res;
      half_cos_sin(angle, c, s);
      q[0] = c;
      q[1] = (s * longint'(ax)) >>> 14;
      q[2] = (s * longint'(ay)) >>> 14;
      q[3] = (s * longint'(az)) >>> 14;
      qc[0] = q[0];
      for (int k = 1; k < 4; k++) qc[k] = -q[k];
      if (mode == MODE_CHAIN) p = prev_point;
      else p = '{longint'(pw), longint'(px), longint'(py), longint'(pz)};
      hamilton(q, p, t);
      hamilton(t, qc, r);
      for (int k = 0; k < 4; k++) begin
         v = (r[k] + (longint'(1) << 31)) >>> 32;
         if (v > 131071) v = 131071;
         if (v < -131072) v = -131072;
         prev_point[k] = v;
      end
      res.w = PW'(prev_point[0]);
      res.x = PW'(prev_point[1]);
      res.y = PW'(prev_point[2]);
      res.z = PW'(prev_point[3]);
      return res;
   endfunction

   // send one beat and hold it until taken, then maybe idle
   task automatic send_beat(input logic mode, input logic signed [AGW-1:0] angle, ax, ay, az,
                            input logic signed [PW-1:0] pw, px, py, pz);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_angle   <= angle;
      req_axis_x  <= ax;
      req_axis_y  <= ay;
      req_axis_z  <= az;
      req_point_w <= pw;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      do @(posedge clock); while (req_stall);
      expected_points.push_back(rotate_point(mode, angle, ax, ay, az, pw, px, py, pz));
      if (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [AGW-1:0] pick_axis();
      case ($urandom_range(9))
         0, 1, 2: return $urandom_range(1) ? AGW'(16384) : -AGW'(16384);
         3:       return AGW'(0);
         4:       return AGW'($urandom);
         default: return AGW'(int'($urandom_range(32768)) - 16384);
      endcase
   endfunction

   task automatic send_random(input logic mode);
      send_beat(mode, AGW'($urandom), pick_axis(), pick_axis(), pick_axis(),
                PW'($urandom), PW'($urandom), PW'($urandom), PW'($urandom));
   endtask

   // extremes of every field, chaining from reset, saturation, non-unit axes
   task automatic test_directed();
      send_beat(MODE_CHAIN, 16'sd4096, 16'sd16384, 0, 0, 0, 0, 0, 0);
      send_beat(MODE_POINT, 0, 0, 0, 16'sd16384, 18'sd1024, 18'sd1024, 18'sd1024, 18'sd1024);
      send_beat(MODE_POINT, 16'sd32767, 16'sd16384, 0, 0, 18'sd131071, 18'sd131071,
                -18'sd131072, 18'sd131071);
      send_beat(MODE_POINT, -16'sd32768, 0, 16'sd16384, 0, -18'sd131072, -18'sd131072,
                18'sd131071, -18'sd131072);
      send_beat(MODE_POINT, 16'sd12868, 0, 0, -16'sd16384, 0, 18'sd1024, 0, 0);
      send_beat(MODE_POINT, -16'sd12868, -16'sd16384, 0, 0, 0, 0, 18'sd2048, 0);
      send_beat(MODE_POINT, 16'sd25736, 0, -16'sd16384, 0, 0, 0, 0, 18'sd4096);
      send_beat(MODE_POINT, 16'sd8192, -16'sd32768, 16'sd32767, -16'sd32768,
                18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071);
      send_beat(MODE_POINT, 16'sd6000, 16'sd9459, 16'sd9459, 16'sd9459, 18'sd500,
                -18'sd700, 18'sd900, 18'sd100);
      send_beat(MODE_CHAIN, 16'sd6000, 16'sd9459, 16'sd9459, 16'sd9459, 0, 0, 0, 0);
      send_beat(MODE_CHAIN, -16'sd6000, 16'sd9459, 16'sd9459, 16'sd9459, 18'sd1, 0, 0, 0);
      send_beat(MODE_POINT, 16'sd12869, 16'sd32767, 16'sd32767, 16'sd32767,
                -18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071);
      send_beat(MODE_POINT, -16'sd1, 16'sd1, -16'sd1, 16'sd16384, -18'sd1, 18'sd1, -18'sd1,
                18'sd1);
      wait_empty();
   endtask

   // chains of rotations from a fresh point
   task automatic test_chained();
      repeat (20) begin
         send_random(MODE_POINT);
         repeat ($urandom_range(1, 4)) send_random(MODE_CHAIN);
      end
      wait_empty();
   endtask

   // random mix, with a stretch of no idling on either side
   task automatic test_random();
      for (int n = 0; n < 370; n++) begin
         idle_on = !(n >= 100 && n < 180);
         send_random($urandom_range(3) == 0 ? MODE_CHAIN : MODE_POINT);
      end
      idle_on = 1'b1;
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 29);
   end

   task automatic report_mismatch(input string field, input logic signed [PW-1:0] got, exp_v);
      $display("mismatch on %s: got %0d expected %0d at cycle %0d", field, got, exp_v, cycles);
      fail_count++;
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rot_point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("unexpected result beat at cycle %0d", cycles);
            fail_count++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_out_w !== e.w) report_mismatch("out_w", rsp_out_w, e.w);
            if (rsp_out_x !== e.x) report_mismatch("out_x", rsp_out_x, e.x);
            if (rsp_out_y !== e.y) report_mismatch("out_y", rsp_out_y, e.y);
            if (rsp_out_z !== e.z) report_mismatch("out_z", rsp_out_z, e.z);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_chained();
      test_random();
      wait_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_points.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
